@@ rtl/bmpt_pkg.sv @@
// Shared constants, types and state encoding for the binomial mod-prime table engine.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package bmpt_pkg;

  localparam int unsigned VALUE_W  = 30;
  localparam int unsigned N_W      = 12;
  localparam int unsigned R_W      = 13;
  localparam int unsigned EXP_BITS = 30;
  localparam int unsigned BIT_W    = 5;

  localparam int unsigned DEF_TABLE_SIZE = 4096;

  localparam logic [VALUE_W-1:0] PRIME_MOD = 30'd998244353;
  // Fermat inverse exponent, p - 2
  localparam logic [VALUE_W-1:0] INV_EXP   = 30'd998244351;

  // Barrett factor floor(2^60 / p), fits in 31 bits
  localparam logic [63:0] BarrettMu64 = (64'd1 << 60) / 64'd998244353;
  localparam logic [30:0] BARRETT_MU  = BarrettMu64[30:0];

  localparam logic MODE_BUILD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_BUILT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FACT_ISSUE,
    ST_FACT_WAIT,
    ST_POW_MUL,
    ST_POW_MUL_WAIT,
    ST_POW_SQR,
    ST_POW_SQR_WAIT,
    ST_INV_ISSUE,
    ST_INV_WAIT,
    ST_Q_READ2,
    ST_Q_WAIT1,
    ST_Q_MUL2,
    ST_Q_WAIT2,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] res;
  } mm_rsp_t;

endpackage

@@ rtl/bmpt_in_if.sv @@
// Input channel of the binomial table engine: valid/ready plus mode, n, r.
// Depends on bmpt_pkg for field widths.
`timescale 1ns / 1ps

interface bmpt_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [bmpt_pkg::N_W-1:0]          n;
  logic signed [bmpt_pkg::R_W-1:0]   r;

  modport source (output valid, output mode, output n, output r, input ready);
  modport sink   (input valid, input mode, input n, input r, output ready);
endinterface

@@ rtl/bmpt_out_if.sv @@
// Output channel of the binomial table engine: valid/ready plus value, status.
// Depends on bmpt_pkg for field widths.
`timescale 1ns / 1ps

interface bmpt_out_if;
  logic                         valid;
  logic                         ready;
  logic [bmpt_pkg::VALUE_W-1:0] value;
  logic                         status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

@@ rtl/bmpt_modmul.sv @@
// Four-stage pipelined multiplier modulo 998244353 using Barrett reduction.
// Depends on bmpt_pkg.
`timescale 1ns / 1ps

module bmpt_modmul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bmpt_pkg::mm_req_t req_i,
  output bmpt_pkg::mm_rsp_t rsp_o
);

  localparam logic [31:0] P1 = 32'(bmpt_pkg::PRIME_MOD);
  localparam logic [31:0] P2 = 32'(bmpt_pkg::PRIME_MOD) << 1;

  logic [3:0]  vld_q;
  logic [59:0] prod_d, prod_q;
  logic [61:0] q2_d, q2_q;
  logic [60:0] qp_full;
  logic [31:0] x2_q, x3_q, qp_q;
  logic [31:0] diff, corr;
  logic [bmpt_pkg::VALUE_W-1:0] res_q;

  assign prod_d  = req_i.a * req_i.b;
  // q1 = x >> 29, q3 = (q1 * mu) >> 31; remainder estimate is within 3p
  assign q2_d    = prod_q[59:29] * bmpt_pkg::BARRETT_MU;
  assign qp_full = q2_q[61:31] * bmpt_pkg::PRIME_MOD;
  assign diff    = x3_q - qp_q;
  assign corr    = (diff >= P2) ? (diff - P2) :
                   (diff >= P1) ? (diff - P1) : diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], req_i.start};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    q2_q   <= q2_d;
    x2_q   <= prod_q[31:0];
    x3_q   <= x2_q;
    qp_q   <= qp_full[31:0];
    res_q  <= corr[29:0];
  end

  assign rsp_o.done = vld_q[3];
  assign rsp_o.res  = res_q;

  a_res_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> (rsp_o.res < bmpt_pkg::PRIME_MOD))
    else $error("modmul result not reduced");

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> ##4 rsp_o.done)
    else $error("modmul result missing four cycles after start");

  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> $past(req_i.start, 4))
    else $error("modmul result without a start");

endmodule

@@ rtl/binomial_mod_prime_table_engine.sv @@
// Top level: binomial coefficients mod 998244353 from factorial tables in block RAM.
// Depends on bmpt_pkg, bmpt_in_if, bmpt_out_if and bmpt_modmul.
`timescale 1ns / 1ps

// Usage
//   in_i  : one transaction per item. mode = build writes both tables; mode = query
//           asks for C(n, r) mod p. Taken only while the engine is idle.
//   out_o : exactly one transaction per item (value, status). A build answers 0/ok,
//           a query before any build answers 0/not-built, r < 0, r > n or
//           n >= TABLE_SIZE answer 0/ok.
// Multiplier use
//   Every product goes through the four-stage modular multiplier, one at a time.
//   Query: two chained products, fact[n] * invf[r] and then that times invf[n-r].
//   Early answers (not built, index out of range): no product, final state at once.
//   Build: one product per factorial entry, one per inverse entry, plus the
//   exponentiation that raises the last factorial to the power p - 2.
// Reset
//   Clears control state and the tables-built flag; the table RAMs keep contents
//   and are never read before a build has written them. No clearing pass.
// Stall
//   The result sits in an output register; the next item is taken while it waits.
//   A finished item holds in its final state until that register is free.

module binomial_mod_prime_table_engine #(
  parameter int unsigned TABLE_SIZE = bmpt_pkg::DEF_TABLE_SIZE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmpt_in_if.sink     in_i,
  bmpt_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);
  localparam int unsigned VW = bmpt_pkg::VALUE_W;
  localparam int unsigned BW = bmpt_pkg::BIT_W;
  localparam logic [BW-1:0] LAST_BIT = BW'(bmpt_pkg::EXP_BITS - 1);

  bmpt_pkg::state_e state_q, state_d;

  logic [AW-1:0]                 cnt_q, cnt_d;
  logic [AW-1:0]                 nr_q, nr_d;
  logic [BW-1:0]                 bit_q, bit_d;
  logic [VW-1:0]                 acc_q, acc_d;
  logic [VW-1:0]                 base_q, base_d;
  logic                          tables_ready_q, tables_ready_d;
  logic [VW-1:0]                 res_value_q, res_value_d;
  logic                          res_status_q, res_status_d;
  logic                          out_valid_q, out_valid_d;
  logic [VW-1:0]                 out_value_q, out_value_d;
  logic                          out_status_q, out_status_d;

  logic [VW-1:0] fact_mem [TABLE_SIZE];
  logic [VW-1:0] inv_mem  [TABLE_SIZE];
  logic          fact_we, fact_re, inv_we, inv_re;
  logic [AW-1:0] fact_waddr, fact_raddr, inv_waddr, inv_raddr;
  logic [VW-1:0] fact_wdata, inv_wdata, fact_rd_q, inv_rd_q;

  bmpt_pkg::mm_req_t mm_req;
  bmpt_pkg::mm_rsp_t mm_rsp;

  logic [31:0] n_ext, r_ext, nr_ext;
  logic        q_ok;

  bmpt_modmul u_modmul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mm_req),
    .rsp_o (mm_rsp)
  );

  assign n_ext  = 32'(in_i.n);
  assign r_ext  = 32'(in_i.r[11:0]);
  assign nr_ext = n_ext - r_ext;
  assign q_ok   = !in_i.r[12] && (in_i.r[11:0] <= in_i.n) && (n_ext < 32'(TABLE_SIZE));

  assign in_i.ready   = (state_q == bmpt_pkg::ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    nr_d           = nr_q;
    bit_d          = bit_q;
    acc_d          = acc_q;
    base_d         = base_q;
    tables_ready_d = tables_ready_q;
    res_value_d    = res_value_q;
    res_status_d   = res_status_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    out_value_d    = out_value_q;
    out_status_d   = out_status_q;
    fact_we        = 1'b0;
    fact_waddr     = cnt_q;
    fact_wdata     = mm_rsp.res;
    fact_re        = 1'b0;
    fact_raddr     = n_ext[AW-1:0];
    inv_we         = 1'b0;
    inv_waddr      = cnt_q;
    inv_wdata      = mm_rsp.res;
    inv_re         = 1'b0;
    inv_raddr      = r_ext[AW-1:0];
    mm_req.start   = 1'b0;
    mm_req.a       = acc_q;
    mm_req.b       = 30'(cnt_q);

    case (state_q)
      bmpt_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.mode == bmpt_pkg::MODE_BUILD) begin
            fact_we    = 1'b1;
            fact_waddr = '0;
            fact_wdata = 30'd1;
            acc_d      = 30'd1;
            cnt_d      = AW'(1);
            state_d    = bmpt_pkg::ST_FACT_ISSUE;
          end else if (!tables_ready_q) begin
            res_value_d  = '0;
            res_status_d = bmpt_pkg::STATUS_NOT_BUILT;
            state_d      = bmpt_pkg::ST_FINISH;
          end else if (!q_ok) begin
            res_value_d  = '0;
            res_status_d = bmpt_pkg::STATUS_OK;
            state_d      = bmpt_pkg::ST_FINISH;
          end else begin
            fact_re = 1'b1;
            inv_re  = 1'b1;
            nr_d    = nr_ext[AW-1:0];
            state_d = bmpt_pkg::ST_Q_READ2;
          end
        end
      end

      bmpt_pkg::ST_FACT_ISSUE: begin
        mm_req.start = 1'b1;
        state_d      = bmpt_pkg::ST_FACT_WAIT;
      end

      bmpt_pkg::ST_FACT_WAIT: begin
        if (mm_rsp.done) begin
          fact_we = 1'b1;
          acc_d   = mm_rsp.res;
          if (cnt_q == LAST_IDX) begin
            // invert the last factorial: acc = fact^(p-2)
            base_d  = mm_rsp.res;
            acc_d   = 30'd1;
            bit_d   = '0;
            state_d = bmpt_pkg::ST_POW_MUL;
          end else begin
            cnt_d   = cnt_q + AW'(1);
            state_d = bmpt_pkg::ST_FACT_ISSUE;
          end
        end
      end

      bmpt_pkg::ST_POW_MUL: begin
        if (bmpt_pkg::INV_EXP[bit_q]) begin
          mm_req.start = 1'b1;
          mm_req.b     = base_q;
          state_d      = bmpt_pkg::ST_POW_MUL_WAIT;
        end else begin
          state_d      = bmpt_pkg::ST_POW_SQR;
        end
      end

      bmpt_pkg::ST_POW_MUL_WAIT: begin
        if (mm_rsp.done) begin
          acc_d   = mm_rsp.res;
          state_d = bmpt_pkg::ST_POW_SQR;
        end
      end

      bmpt_pkg::ST_POW_SQR: begin
        mm_req.start = 1'b1;
        mm_req.a     = base_q;
        mm_req.b     = base_q;
        state_d      = bmpt_pkg::ST_POW_SQR_WAIT;
      end

      bmpt_pkg::ST_POW_SQR_WAIT: begin
        if (mm_rsp.done) begin
          base_d = mm_rsp.res;
          if (bit_q == LAST_BIT) begin
            inv_we    = 1'b1;
            inv_waddr = LAST_IDX;
            inv_wdata = acc_q;
            cnt_d     = LAST_IDX;
            state_d   = bmpt_pkg::ST_INV_ISSUE;
          end else begin
            bit_d   = bit_q + BW'(1);
            state_d = bmpt_pkg::ST_POW_MUL;
          end
        end
      end

      bmpt_pkg::ST_INV_ISSUE: begin
        mm_req.start = 1'b1;
        state_d      = bmpt_pkg::ST_INV_WAIT;
      end

      bmpt_pkg::ST_INV_WAIT: begin
        if (mm_rsp.done) begin
          // invf[i-1] = invf[i] * i; the last step writes invf[0] = 1
          inv_we    = 1'b1;
          inv_waddr = cnt_q - AW'(1);
          acc_d     = mm_rsp.res;
          if (cnt_q == AW'(1)) begin
            tables_ready_d = 1'b1;
            res_value_d    = '0;
            res_status_d   = bmpt_pkg::STATUS_OK;
            state_d        = bmpt_pkg::ST_FINISH;
          end else begin
            cnt_d   = cnt_q - AW'(1);
            state_d = bmpt_pkg::ST_INV_ISSUE;
          end
        end
      end

      bmpt_pkg::ST_Q_READ2: begin
        // fact[n] and invf[r] are in the read registers; fetch invf[n-r] meanwhile
        mm_req.start = 1'b1;
        mm_req.a     = fact_rd_q;
        mm_req.b     = inv_rd_q;
        inv_re       = 1'b1;
        inv_raddr    = nr_q;
        state_d      = bmpt_pkg::ST_Q_WAIT1;
      end

      bmpt_pkg::ST_Q_WAIT1: begin
        if (mm_rsp.done) begin
          acc_d   = mm_rsp.res;
          state_d = bmpt_pkg::ST_Q_MUL2;
        end
      end

      bmpt_pkg::ST_Q_MUL2: begin
        mm_req.start = 1'b1;
        mm_req.b     = inv_rd_q;
        state_d      = bmpt_pkg::ST_Q_WAIT2;
      end

      bmpt_pkg::ST_Q_WAIT2: begin
        if (mm_rsp.done) begin
          res_value_d  = mm_rsp.res;
          res_status_d = bmpt_pkg::STATUS_OK;
          state_d      = bmpt_pkg::ST_FINISH;
        end
      end

      bmpt_pkg::ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
          state_d      = bmpt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bmpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= bmpt_pkg::ST_IDLE;
      tables_ready_q <= 1'b0;
      out_valid_q    <= 1'b0;
      cnt_q          <= '0;
      bit_q          <= '0;
    end else begin
      state_q        <= state_d;
      tables_ready_q <= tables_ready_d;
      out_valid_q    <= out_valid_d;
      cnt_q          <= cnt_d;
      bit_q          <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nr_q         <= nr_d;
    acc_q        <= acc_d;
    base_q       <= base_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  // Table RAMs. Reads happen only in query states and writes only in build
  // states, so the same entry is never read and written in one cycle.
  always_ff @(posedge clk_i) begin
    if (fact_we) begin
      fact_mem[fact_waddr] <= fact_wdata;
    end
    if (fact_re) begin
      fact_rd_q <= fact_mem[fact_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (inv_we) begin
      inv_mem[inv_waddr] <= inv_wdata;
    end
    if (inv_re) begin
      inv_rd_q <= inv_mem[inv_raddr];
    end
  end

  a_read_after_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fact_re || inv_re) |-> tables_ready_q)
    else $error("table read before tables were built");

  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(tables_ready_q))
    else $error("tables-built flag dropped");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_rsp.done |-> (state_q == bmpt_pkg::ST_FACT_WAIT ||
                     state_q == bmpt_pkg::ST_POW_MUL_WAIT ||
                     state_q == bmpt_pkg::ST_POW_SQR_WAIT ||
                     state_q == bmpt_pkg::ST_INV_WAIT ||
                     state_q == bmpt_pkg::ST_Q_WAIT1 ||
                     state_q == bmpt_pkg::ST_Q_WAIT2))
    else $error("multiplier result arrived outside a wait state");

endmodule

@@ dv/binomial_mod_prime_table_engine_tb.sv @@
// Testbench for binomial_mod_prime_table_engine: checks builds and C(n, r) mod p queries
// against a behavioral table model. Depends on bmpt_pkg, bmpt_in_if and bmpt_out_if.
`timescale 1ns / 1ps

module binomial_mod_prime_table_engine_tb;

  localparam int unsigned TBL_SIZE    = bmpt_pkg::DEF_TABLE_SIZE;
  localparam int unsigned VW          = bmpt_pkg::VALUE_W;
  localparam int unsigned NW          = bmpt_pkg::N_W;
  localparam int unsigned RW          = bmpt_pkg::R_W;
  localparam int unsigned RAND_ITEMS  = 1600;
  localparam int unsigned MAX_BUILDS  = 4;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_AT     = 60;
  localparam int unsigned HOLD_LEN    = 500;
  localparam int unsigned DRAIN_CYC   = 20;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic                    mode;
    logic [NW-1:0]           n;
    logic signed [RW-1:0]    r;
    int unsigned             gap;
  } engine_item_t;

  typedef struct {
    logic [VW-1:0] value;
    logic          status;
  } coeff_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bmpt_in_if  in_if ();
  bmpt_out_if out_if ();

  binomial_mod_prime_table_engine #(
    .TABLE_SIZE(TBL_SIZE)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Behavioral copy of the engine state
  logic [VW-1:0] fact_tbl [TBL_SIZE];
  logic [VW-1:0] inv_fact_tbl [TBL_SIZE];
  logic          tables_built;

  engine_item_t  pending_items [$];
  coeff_result_t expected_coeffs [$];
  engine_item_t  driven_item;

  int unsigned total_items;
  int unsigned accepted_count;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned idle_count;
  int unsigned stall_left;
  int unsigned hold_cnt;
  logic        hold_done;
  int unsigned cycle_count;

  function automatic logic [VW-1:0] mod_product(logic [VW-1:0] a, logic [VW-1:0] b);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b);
    return VW'(prod % 64'(bmpt_pkg::PRIME_MOD));
  endfunction

  function automatic logic [VW-1:0] mod_power(logic [VW-1:0] base, logic [VW-1:0] expo);
    logic [VW-1:0] acc;
    logic [VW-1:0] sq;
    acc = 1;
    sq  = base;
    for (int i = 0; i < VW; i++) begin
      if (expo[i]) acc = mod_product(acc, sq);
      sq = mod_product(sq, sq);
    end
    return acc;
  endfunction

  task automatic fill_tables();
    fact_tbl[0] = 1;
    for (int unsigned i = 1; i < TBL_SIZE; i++)
      fact_tbl[i] = mod_product(fact_tbl[i-1], VW'(i));
    inv_fact_tbl[TBL_SIZE-1] = mod_power(fact_tbl[TBL_SIZE-1], bmpt_pkg::INV_EXP);
    for (int unsigned i = TBL_SIZE - 1; i >= 2; i--)
      inv_fact_tbl[i-1] = mod_product(inv_fact_tbl[i], VW'(i));
    inv_fact_tbl[0] = 1;
    tables_built = 1'b1;
  endtask

  task automatic binomial_predict(engine_item_t it);
    coeff_result_t res;
    int            nv;
    int            rv;
    nv = int'(it.n);
    rv = int'(it.r);
    res.value  = '0;
    res.status = bmpt_pkg::STATUS_OK;
    if (it.mode == bmpt_pkg::MODE_BUILD) begin
      fill_tables();
    end else if (!tables_built) begin
      res.status = bmpt_pkg::STATUS_NOT_BUILT;
    end else if (rv >= 0 && rv <= nv && nv < int'(TBL_SIZE)) begin
      res.value = mod_product(mod_product(fact_tbl[nv], inv_fact_tbl[rv]),
                              inv_fact_tbl[nv - rv]);
    end
    expected_coeffs.push_back(res);
  endtask

  task automatic add_item(logic mode, logic [NW-1:0] n, logic signed [RW-1:0] r,
                          int unsigned gap);
    engine_item_t it;
    it.mode = mode;
    it.n    = n;
    it.r    = r;
    it.gap  = gap;
    pending_items.push_back(it);
    total_items++;
  endtask

  // Driver: one transaction in flight on in_if, idle cycles taken from each item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.mode  <= bmpt_pkg::MODE_QUERY;
      in_if.n     <= '0;
      in_if.r     <= '0;
      idle_count  = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        binomial_predict(driven_item);
        accepted_count++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (idle_count < pending_items[0].gap) begin
          idle_count++;
          in_if.valid <= 1'b0;
        end else begin
          driven_item = pending_items.pop_front();
          idle_count  = 0;
          in_if.mode  <= driven_item.mode;
          in_if.n     <= driven_item.n;
          in_if.r     <= driven_item.r;
          in_if.valid <= 1'b1;
        end
      end
    end
  end

  // Long receiver hold-off so the engine fills and backs up its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    coeff_result_t exp_res;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_coeffs.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: value %0d status %0d",
                     out_if.value, out_if.status);
        end else begin
          exp_res = expected_coeffs.pop_front();
          if (out_if.value !== exp_res.value || out_if.status !== exp_res.status) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display({"mismatch on result %0d: expected value %0d status %0d, ",
                        "got value %0d status %0d"},
                       results_seen, exp_res.value, exp_res.status,
                       out_if.value, out_if.status);
          end
        end
        // every fourth block of 100 results runs without stalls
        stall_left = ((results_seen / 100) % 4 == 3) ? 0 : $urandom_range(0, 3);
      end
      if (hold_cnt != 0) begin
        out_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned          builds;
    int unsigned          gap;
    int unsigned          pick;
    logic [NW-1:0]        nv;
    logic signed [RW-1:0] rv;

    in_if.valid  = 1'b0;
    in_if.mode   = bmpt_pkg::MODE_QUERY;
    in_if.n      = '0;
    in_if.r      = '0;
    out_if.ready = 1'b0;
    tables_built = 1'b0;
    total_items    = 0;
    accepted_count = 0;
    results_seen   = 0;
    error_count    = 0;
    builds         = 0;

    // queries ahead of any build report not-built
    add_item(bmpt_pkg::MODE_QUERY, 12'd5, 13'sd2, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd0, 13'sd0, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_BUILD, 12'd0, 13'sd0, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd0, 13'sd0, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd4095, 13'sd0, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd4095, 13'sd4095, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd4095, 13'sd2048, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd4095, -13'sd1, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd4095, -13'sd4096, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd0, 13'sd4095, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd0, 13'sd1, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd1, 13'sd1, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd10, 13'sd3, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd4094, 13'sd4095, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd2047, 13'sd1000, $urandom_range(0, 3));
    // rebuild with junk index fields, results must not change
    add_item(bmpt_pkg::MODE_BUILD, 12'd4095, -13'sd1, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd100, 13'sd50, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd4095, 13'sd4094, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd2730, 13'sd1365, $urandom_range(0, 3));
    add_item(bmpt_pkg::MODE_QUERY, 12'd1365, -13'sd2731, $urandom_range(0, 3));

    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      gap  = ((i / 100) % 4 == 1) ? 0 : $urandom_range(0, 3);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 70) nv = NW'($urandom());
      else nv = NW'($urandom_range(0, 15));
      if (builds < MAX_BUILDS && $urandom_range(0, 499) == 0) begin
        builds++;
        add_item(bmpt_pkg::MODE_BUILD, NW'($urandom()), RW'($urandom()), gap);
      end else begin
        if (pick < 75) begin
          rv = RW'($urandom_range(0, nv));
        end else if (pick < 85 && nv != 12'd4095) begin
          rv = RW'($urandom_range(int'(nv) + 1, 4095));
        end else if (pick < 95) begin
          rv = -RW'($urandom_range(1, 4096));
        end else begin
          rv = RW'($urandom());
        end
        add_item(bmpt_pkg::MODE_QUERY, nv, rv, gap);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count != total_items) @(posedge clk_i);
    while (expected_coeffs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
